### rtl/core/ptsd_pkg.sv
// Shared types, widths and vector helpers for the point-to-triangle squared distance block.
// No dependencies; every other file in rtl/core imports this package.
package ptsd_pkg;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = 17;
    localparam int DOT_W     = 36;
    localparam int PROD_W    = 72;
    localparam int GRAM_W    = 74;
    localparam int DN_W      = 56;
    localparam int DEN_W     = 70;
    localparam int DIST_W    = 34;
    localparam int OUT_W     = 42;
    localparam int NUM_LANES = 4;

    // split of |d.n| for the partial-product square
    localparam int SPLIT_W = 28;
    localparam int HI_W    = DN_W - 1 - SPLIT_W;
    localparam int HH_W    = 2 * HI_W;
    localparam int HL_W    = HI_W + SPLIT_W;
    localparam int LL_W    = 2 * SPLIT_W;
    localparam int SQ_W    = 2 * (DN_W - 1);

    // divider lanes
    localparam int LANE_FACE   = 0;
    localparam int LANE_EDGE_A = 1;
    localparam int LANE_EDGE_B = 2;
    localparam int LANE_EDGE_C = 3;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] third_x;
        logic signed [COORD_W-1:0] third_y;
        logic signed [COORD_W-1:0] third_z;
    } query_t;

    typedef struct packed {
        logic [OUT_W-1:0] squared_distance;
        logic             on_face;
    } result_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [DOT_W-1:0] x;
        logic signed [DOT_W-1:0] y;
        logic signed [DOT_W-1:0] z;
    } wvec_t;

    // travels alongside the divider lanes
    typedef struct packed {
        logic              face;
        logic [2:0]        edge_ok;
        logic [DIST_W-1:0] vert_min;
    } side_t;

    function automatic logic signed [DIFF_W-1:0] sub16(
        logic signed [COORD_W-1:0] u,
        logic signed [COORD_W-1:0] v
    );
        return DIFF_W'(u) - DIFF_W'(v);
    endfunction

    function automatic logic signed [DOT_W-1:0] dot3(vec_t u, vec_t v);
        logic signed [DOT_W-1:0] px;
        logic signed [DOT_W-1:0] py;
        logic signed [DOT_W-1:0] pz;
        px = DOT_W'(u.x) * DOT_W'(v.x);
        py = DOT_W'(u.y) * DOT_W'(v.y);
        pz = DOT_W'(u.z) * DOT_W'(v.z);
        return px + py + pz;
    endfunction

    function automatic wvec_t cross3(vec_t u, vec_t v);
        wvec_t r;
        r.x = DOT_W'(u.y) * DOT_W'(v.z) - DOT_W'(u.z) * DOT_W'(v.y);
        r.y = DOT_W'(u.z) * DOT_W'(v.x) - DOT_W'(u.x) * DOT_W'(v.z);
        r.z = DOT_W'(u.x) * DOT_W'(v.y) - DOT_W'(u.y) * DOT_W'(v.x);
        return r;
    endfunction

endpackage

### rtl/core/ptsd_geom.sv
// Five-stage geometry front end: edge vectors, dot and cross products, barycentric
// numerators, face test and divider lane setup. Depends on ptsd_pkg.
module ptsd_geom #(
    parameter int FRAC_BITS = 8,
    localparam int QW = ptsd_pkg::DIST_W + FRAC_BITS,
    localparam int NW = ptsd_pkg::DEN_W + QW
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                adv,
    input  logic                                                query_valid,
    input  ptsd_pkg::query_t                                    query,
    output logic                                                out_valid,
    output logic [ptsd_pkg::NUM_LANES-1:0][NW-1:0]              out_num,
    output logic [ptsd_pkg::NUM_LANES-1:0][ptsd_pkg::DEN_W-1:0] out_den,
    output ptsd_pkg::side_t                                     out_side
);
    import ptsd_pkg::*;

    localparam int SUM_W = GRAM_W + 1;

    // stage 1
    vec_t a_next, b_next, d_next, w1_next, c_next, e3_next;
    vec_t a_reg, b_reg, d_reg, w1_reg, c_reg, e3_reg;
    // stage 2
    logic signed [DOT_W-1:0] aa_next, bb_next, ab_next, da_next, db_next;
    logic signed [DOT_W-1:0] ee3_next, we3_next, dd_next, w1w1_next, cc_next;
    logic signed [DOT_W-1:0] aa_reg, bb_reg, ab_reg, da_reg, db_reg;
    logic signed [DOT_W-1:0] ee3_reg, we3_reg, dd_reg, w1w1_reg, cc_reg;
    wvec_t n_next, x1_next, x2_next, x3_next;
    wvec_t n_reg, x1_reg, x2_reg, x3_reg;
    vec_t  d2_next, d2_reg;
    // stage 3
    logic signed [PROD_W-1:0] bbda_next, abdb_next, aadb_next, abda_next, aabb_next, abab_next;
    logic signed [PROD_W-1:0] bbda_reg, abdb_reg, aadb_reg, abda_reg, aabb_reg, abab_reg;
    logic signed [DN_W-1:0]   dn_next, dn_reg;
    logic [2:0][PROD_W-1:0]   sqa_next, sqb_next, sqc_next;
    logic [2:0][PROD_W-1:0]   sqa_reg, sqb_reg, sqc_reg;
    logic [2:0]               ok3_next, ok3_reg;
    logic [DIST_W-1:0]        vmin3_next, vmin3_reg;
    logic [DIST_W-1:0]        dena3_next, denb3_next, denc3_next;
    logic [DIST_W-1:0]        dena3_reg, denb3_reg, denc3_reg;
    // stage 4
    logic signed [GRAM_W-1:0] s_next, t_next, g_next, s_reg, t_reg, g_reg;
    logic [2:0][DEN_W-1:0]    c2_next, c2_reg;
    logic signed [DN_W-1:0]   dn_mag;
    logic [HH_W-1:0]          hh_next, hh_reg;
    logic [HL_W-1:0]          hl_next, hl_reg;
    logic [LL_W-1:0]          ll_next, ll_reg;
    logic [2:0]               ok4_reg;
    logic [DIST_W-1:0]        vmin4_reg, dena4_reg, denb4_reg, denc4_reg;
    // stage 5
    logic [SQ_W-1:0]                     dn_sq;
    logic                                face;
    logic [NUM_LANES-1:0][NW-1:0]        num_next, num_reg;
    logic [NUM_LANES-1:0][DEN_W-1:0]     den_next, den_reg;
    side_t                               side_next, side_reg;

    logic [4:0] valid_reg;

    always_comb
    begin
        a_next.x  = sub16(query.second_x, query.first_x);
        a_next.y  = sub16(query.second_y, query.first_y);
        a_next.z  = sub16(query.second_z, query.first_z);
        b_next.x  = sub16(query.third_x, query.first_x);
        b_next.y  = sub16(query.third_y, query.first_y);
        b_next.z  = sub16(query.third_z, query.first_z);
        d_next.x  = sub16(query.point_x, query.first_x);
        d_next.y  = sub16(query.point_y, query.first_y);
        d_next.z  = sub16(query.point_z, query.first_z);
        w1_next.x = sub16(query.point_x, query.second_x);
        w1_next.y = sub16(query.point_y, query.second_y);
        w1_next.z = sub16(query.point_z, query.second_z);
        c_next.x  = sub16(query.point_x, query.third_x);
        c_next.y  = sub16(query.point_y, query.third_y);
        c_next.z  = sub16(query.point_z, query.third_z);
        e3_next.x = sub16(query.third_x, query.second_x);
        e3_next.y = sub16(query.third_y, query.second_y);
        e3_next.z = sub16(query.third_z, query.second_z);
    end

    always_comb
    begin
        aa_next   = dot3(a_reg, a_reg);
        bb_next   = dot3(b_reg, b_reg);
        ab_next   = dot3(a_reg, b_reg);
        da_next   = dot3(d_reg, a_reg);
        db_next   = dot3(d_reg, b_reg);
        ee3_next  = dot3(e3_reg, e3_reg);
        we3_next  = dot3(w1_reg, e3_reg);
        dd_next   = dot3(d_reg, d_reg);
        w1w1_next = dot3(w1_reg, w1_reg);
        cc_next   = dot3(c_reg, c_reg);
        n_next    = cross3(a_reg, b_reg);
        x1_next   = cross3(d_reg, a_reg);
        x2_next   = cross3(d_reg, b_reg);
        x3_next   = cross3(w1_reg, e3_reg);
        d2_next   = d_reg;
    end

    always_comb
    begin
        bbda_next = PROD_W'(bb_reg) * PROD_W'(da_reg);
        abdb_next = PROD_W'(ab_reg) * PROD_W'(db_reg);
        aadb_next = PROD_W'(aa_reg) * PROD_W'(db_reg);
        abda_next = PROD_W'(ab_reg) * PROD_W'(da_reg);
        aabb_next = PROD_W'(aa_reg) * PROD_W'(bb_reg);
        abab_next = PROD_W'(ab_reg) * PROD_W'(ab_reg);
        dn_next   = DN_W'(d2_reg.x) * DN_W'(n_reg.x) + DN_W'(d2_reg.y) * DN_W'(n_reg.y)
                  + DN_W'(d2_reg.z) * DN_W'(n_reg.z);
        sqa_next[0] = PROD_W'(x1_reg.x) * PROD_W'(x1_reg.x);
        sqa_next[1] = PROD_W'(x1_reg.y) * PROD_W'(x1_reg.y);
        sqa_next[2] = PROD_W'(x1_reg.z) * PROD_W'(x1_reg.z);
        sqb_next[0] = PROD_W'(x2_reg.x) * PROD_W'(x2_reg.x);
        sqb_next[1] = PROD_W'(x2_reg.y) * PROD_W'(x2_reg.y);
        sqb_next[2] = PROD_W'(x2_reg.z) * PROD_W'(x2_reg.z);
        sqc_next[0] = PROD_W'(x3_reg.x) * PROD_W'(x3_reg.x);
        sqc_next[1] = PROD_W'(x3_reg.y) * PROD_W'(x3_reg.y);
        sqc_next[2] = PROD_W'(x3_reg.z) * PROD_W'(x3_reg.z);
        // an edge counts only when the projection lands strictly inside it
        ok3_next[0] = (aa_reg > 0) && (da_reg > 0) && (da_reg < aa_reg);
        ok3_next[1] = (bb_reg > 0) && (db_reg > 0) && (db_reg < bb_reg);
        ok3_next[2] = (ee3_reg > 0) && (we3_reg > 0) && (we3_reg < ee3_reg);
        vmin3_next = dd_reg[DIST_W-1:0];
        if (w1w1_reg[DIST_W-1:0] < vmin3_next)
        begin
            vmin3_next = w1w1_reg[DIST_W-1:0];
        end
        if (cc_reg[DIST_W-1:0] < vmin3_next)
        begin
            vmin3_next = cc_reg[DIST_W-1:0];
        end
        dena3_next = aa_reg[DIST_W-1:0];
        denb3_next = bb_reg[DIST_W-1:0];
        denc3_next = ee3_reg[DIST_W-1:0];
    end

    always_comb
    begin
        s_next = GRAM_W'(bbda_reg) - GRAM_W'(abdb_reg);
        t_next = GRAM_W'(aadb_reg) - GRAM_W'(abda_reg);
        g_next = GRAM_W'(aabb_reg) - GRAM_W'(abab_reg);
        c2_next[0] = sqa_reg[0][DEN_W-1:0] + sqa_reg[1][DEN_W-1:0] + sqa_reg[2][DEN_W-1:0];
        c2_next[1] = sqb_reg[0][DEN_W-1:0] + sqb_reg[1][DEN_W-1:0] + sqb_reg[2][DEN_W-1:0];
        c2_next[2] = sqc_reg[0][DEN_W-1:0] + sqc_reg[1][DEN_W-1:0] + sqc_reg[2][DEN_W-1:0];
        dn_mag  = dn_reg[DN_W-1] ? -dn_reg : dn_reg;
        hh_next = HH_W'(dn_mag[DN_W-2:SPLIT_W]) * HH_W'(dn_mag[DN_W-2:SPLIT_W]);
        hl_next = HL_W'(dn_mag[DN_W-2:SPLIT_W]) * HL_W'(dn_mag[SPLIT_W-1:0]);
        ll_next = LL_W'(dn_mag[SPLIT_W-1:0]) * LL_W'(dn_mag[SPLIT_W-1:0]);
    end

    always_comb
    begin
        dn_sq = (SQ_W'(hh_reg) << (2 * SPLIT_W)) + (SQ_W'(hl_reg) << (SPLIT_W + 1))
              + SQ_W'(ll_reg);
        face  = (g_reg > 0) && (s_reg > 0) && (t_reg > 0)
              && ((SUM_W'(s_reg) + SUM_W'(t_reg)) < SUM_W'(g_reg));
        num_next[LANE_FACE]   = NW'(dn_sq) << FRAC_BITS;
        num_next[LANE_EDGE_A] = NW'(c2_reg[0]) << FRAC_BITS;
        num_next[LANE_EDGE_B] = NW'(c2_reg[1]) << FRAC_BITS;
        num_next[LANE_EDGE_C] = NW'(c2_reg[2]) << FRAC_BITS;
        den_next[LANE_FACE]   = g_reg[DEN_W-1:0];
        den_next[LANE_EDGE_A] = DEN_W'(dena4_reg);
        den_next[LANE_EDGE_B] = DEN_W'(denb4_reg);
        den_next[LANE_EDGE_C] = DEN_W'(denc4_reg);
        side_next.face     = face;
        side_next.edge_ok  = ok4_reg;
        side_next.vert_min = vmin4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[3:0], query_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            d_reg     <= d_next;
            w1_reg    <= w1_next;
            c_reg     <= c_next;
            e3_reg    <= e3_next;
            aa_reg    <= aa_next;
            bb_reg    <= bb_next;
            ab_reg    <= ab_next;
            da_reg    <= da_next;
            db_reg    <= db_next;
            ee3_reg   <= ee3_next;
            we3_reg   <= we3_next;
            dd_reg    <= dd_next;
            w1w1_reg  <= w1w1_next;
            cc_reg    <= cc_next;
            n_reg     <= n_next;
            x1_reg    <= x1_next;
            x2_reg    <= x2_next;
            x3_reg    <= x3_next;
            d2_reg    <= d2_next;
            bbda_reg  <= bbda_next;
            abdb_reg  <= abdb_next;
            aadb_reg  <= aadb_next;
            abda_reg  <= abda_next;
            aabb_reg  <= aabb_next;
            abab_reg  <= abab_next;
            dn_reg    <= dn_next;
            sqa_reg   <= sqa_next;
            sqb_reg   <= sqb_next;
            sqc_reg   <= sqc_next;
            ok3_reg   <= ok3_next;
            vmin3_reg <= vmin3_next;
            dena3_reg <= dena3_next;
            denb3_reg <= denb3_next;
            denc3_reg <= denc3_next;
            s_reg     <= s_next;
            t_reg     <= t_next;
            g_reg     <= g_next;
            c2_reg    <= c2_next;
            hh_reg    <= hh_next;
            hl_reg    <= hl_next;
            ll_reg    <= ll_next;
            ok4_reg   <= ok3_reg;
            vmin4_reg <= vmin3_reg;
            dena4_reg <= dena3_reg;
            denb4_reg <= denb3_reg;
            denc4_reg <= denc3_reg;
            num_reg   <= num_next;
            den_reg   <= den_next;
            side_reg  <= side_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

### rtl/core/ptsd_div.sv
// Four-lane pipelined restoring divider, one quotient bit per stage, with side data.
// Depends on ptsd_pkg.
module ptsd_div #(
    parameter int QW = 42,
    localparam int NW = ptsd_pkg::DEN_W + QW
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                adv,
    input  logic                                                up_valid,
    input  logic [ptsd_pkg::NUM_LANES-1:0][NW-1:0]              up_num,
    input  logic [ptsd_pkg::NUM_LANES-1:0][ptsd_pkg::DEN_W-1:0] up_den,
    input  ptsd_pkg::side_t                                     up_side,
    output logic                                                dn_valid,
    output logic [ptsd_pkg::NUM_LANES-1:0][QW-1:0]              dn_quot,
    output ptsd_pkg::side_t                                     dn_side
);
    import ptsd_pkg::*;

    typedef logic [NUM_LANES-1:0][DEN_W-1:0] lane_den_t;
    typedef logic [NUM_LANES-1:0][QW-1:0]    lane_q_t;

    lane_den_t rem_next [QW];
    lane_den_t rem_reg  [QW];
    lane_den_t den_next [QW];
    lane_den_t den_reg  [QW];
    lane_q_t   nq_next  [QW+1];
    lane_q_t   nq_reg   [QW+1];
    side_t     side_reg [QW+1];
    logic [QW:0] valid_reg;

    // quotient fits QW bits, so the numerator top part is already below the divisor
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            rem_next[0][l] = up_num[l][NW-1:QW];
            nq_next[0][l]  = up_num[l][QW-1:0];
        end
        den_next[0] = up_den;
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        logic [NUM_LANES-1:0][DEN_W+1:0] trial;
        logic [NUM_LANES-1:0]            qbit;

        always_comb
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                trial[l] = {1'b0, rem_reg[k-1][l], nq_reg[k-1][l][QW-1]}
                         - {2'b00, den_reg[k-1][l]};
                qbit[l]  = !trial[l][DEN_W+1];
                nq_next[k][l] = {nq_reg[k-1][l][QW-2:0], qbit[l]};
            end
        end

        if (k < QW)
        begin : g_rem
            always_comb
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    rem_next[k][l] = qbit[l] ? trial[l][DEN_W-1:0]
                                             : {rem_reg[k-1][l][DEN_W-2:0],
                                                nq_reg[k-1][l][QW-1]};
                end
                den_next[k] = den_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[QW-1:0], up_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_next[k];
            end
            for (int k = 0; k <= QW; k++)
            begin
                nq_reg[k] <= nq_next[k];
            end
            side_reg[0] <= up_side;
            for (int k = 1; k <= QW; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign dn_valid = valid_reg[QW];
    assign dn_quot  = nq_reg[QW];
    assign dn_side  = side_reg[QW];

endmodule

### rtl/core/ptsd_pick.sv
// Two-stage candidate selection: vertex and edge minimum, face override, saturation,
// and the output register. Depends on ptsd_pkg.
module ptsd_pick #(
    parameter int FRAC_BITS = 8,
    localparam int QW = ptsd_pkg::DIST_W + FRAC_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  logic                                   in_valid,
    input  logic [ptsd_pkg::NUM_LANES-1:0][QW-1:0] quot,
    input  ptsd_pkg::side_t                        side,
    output logic                                   result_valid,
    output ptsd_pkg::result_t                      result
);
    import ptsd_pkg::*;

    localparam int XW = (QW > OUT_W) ? QW : OUT_W;

    logic [QW-1:0] vcand, ea, eb, ec;
    logic [QW-1:0] m01_next, m23_next, m01_reg, m23_reg, qf_reg;
    logic          face_reg, a_valid_reg;
    logic [QW-1:0] best;
    logic [XW-1:0] best_x, m01_x;
    logic [OUT_W-1:0] m01_sat;
    result_t       result_next, result_reg;
    logic          result_valid_reg;

    always_comb
    begin
        vcand = QW'(side.vert_min) << FRAC_BITS;
        // a failed edge never wins the minimum
        ea = side.edge_ok[0] ? quot[LANE_EDGE_A] : '1;
        eb = side.edge_ok[1] ? quot[LANE_EDGE_B] : '1;
        ec = side.edge_ok[2] ? quot[LANE_EDGE_C] : '1;
        m01_next = (ea < vcand) ? ea : vcand;
        m23_next = (ec < eb) ? ec : eb;
    end

    always_comb
    begin
        if (face_reg)
        begin
            best = qf_reg;
        end
        else
        begin
            best = (m23_reg < m01_reg) ? m23_reg : m01_reg;
        end
        best_x = XW'(best);
        result_next.squared_distance = (best_x > XW'(OUT_MAX)) ? OUT_MAX : OUT_W'(best_x);
        result_next.on_face          = face_reg;
        m01_x   = XW'(m01_reg);
        m01_sat = (m01_x > XW'(OUT_MAX)) ? OUT_MAX : OUT_W'(m01_x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg      <= in_valid;
            result_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m01_reg    <= m01_next;
            m23_reg    <= m23_next;
            qf_reg     <= quot[LANE_FACE];
            face_reg   <= side.face;
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_off_face_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        adv && a_valid_reg && !face_reg |=> result.squared_distance <= $past(m01_sat))
        else $error("off-face result exceeds vertex/edge-A candidate");

endmodule

### rtl/core/point_triangle_squared_distance.sv
// Squared distance from a 3D integer point to a triangle, fully pipelined: one item is
// accepted every clock cycle while query_stall is low, and each result passes through
// five geometry stages, 35 + FRAC_BITS restoring-divider stages (each but the first
// resolving one quotient bit) and two selection stages including the output register;
// only the divider grows with FRAC_BITS. A stall on the result side freezes the whole
// pipe, so query_stall is high exactly while a result waits and result_stall is high.
// Depends on ptsd_pkg, ptsd_geom, ptsd_div and ptsd_pick.
module point_triangle_squared_distance #(
    parameter int FRAC_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              query_valid,
    output logic              query_stall,
    input  ptsd_pkg::query_t  query,
    output logic              result_valid,
    input  logic              result_stall,
    output ptsd_pkg::result_t result
);
    import ptsd_pkg::*;

    localparam int QW = DIST_W + FRAC_BITS;
    localparam int NW = DEN_W + QW;

    logic                             advance;
    logic                             geom_valid;
    logic [NUM_LANES-1:0][NW-1:0]     geom_num;
    logic [NUM_LANES-1:0][DEN_W-1:0]  geom_den;
    side_t                            geom_side;
    logic                             div_valid;
    logic [NUM_LANES-1:0][QW-1:0]     div_quot;
    side_t                            div_side;

    // advance the whole pipe unless a finished item is held at the output
    assign advance     = !result_valid || !result_stall;
    assign query_stall = !advance;

    ptsd_geom #(
        .FRAC_BITS(FRAC_BITS)
    ) u_geom (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (advance),
        .query_valid(query_valid),
        .query      (query),
        .out_valid  (geom_valid),
        .out_num    (geom_num),
        .out_den    (geom_den),
        .out_side   (geom_side)
    );

    ptsd_div #(
        .QW(QW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (advance),
        .up_valid(geom_valid),
        .up_num  (geom_num),
        .up_den  (geom_den),
        .up_side (geom_side),
        .dn_valid(div_valid),
        .dn_quot (div_quot),
        .dn_side (div_side)
    );

    ptsd_pick #(
        .FRAC_BITS(FRAC_BITS)
    ) u_pick (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (advance),
        .in_valid    (div_valid),
        .quot        (div_quot),
        .side        (div_side),
        .result_valid(result_valid),
        .result      (result)
    );

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        query_stall |-> result_valid)
        else $error("input stalled with no result waiting");

    a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(geom_valid) && $stable(div_valid))
        else $error("pipeline moved while output was stalled");

endmodule
